FILE: rtl/blist_pkg.sv
// Shared types and constants for the bounded indexed list.
// No dependencies; imported by every module in rtl/.
package blist_pkg;

    // Index and count width; holds values up to 127.
    localparam int IDX_W  = 7;
    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_REM_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE
    } blist_cmd_t;

    // Broadcast to every cell of the chain each cycle.
    typedef struct packed {
        blist_cmd_t          cmd;
        logic [IDX_W-1:0]    pos;
        logic [IDX_W-1:0]    fill;
        logic [WORD_W-1:0]   word;
    } blist_chain_t;

endpackage

FILE: rtl/blist_cell.sv
// One storage cell of the list chain.
// Depends on blist_pkg for the chain control struct.
module blist_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  blist_pkg::blist_chain_t       chain,
    input  logic [blist_pkg::WORD_W-1:0]  left_word,
    input  logic [blist_pkg::WORD_W-1:0]  right_word,
    input  logic [blist_pkg::WORD_W-1:0]  head_word,
    output logic [blist_pkg::WORD_W-1:0]  word
);
    import blist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (chain.cmd)
            CMD_INSERT:
            begin
                if (MY_IDX > chain.pos)
                    word_next = left_word;
                else if (MY_IDX == chain.pos)
                    word_next = chain.word;
            end
            CMD_REMOVE:
            begin
                if (MY_IDX >= chain.pos)
                    word_next = right_word;
            end
            CMD_ROTATE:
            begin
                // head wraps around to the tail so a full pass restores order
                if (MY_IDX + IDX_W'(1) == chain.fill)
                    word_next = head_word;
                else if (MY_IDX < chain.fill)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

FILE: rtl/blist_ctrl.sv
// Sequencer for the list: count, operation checks, dump pass, result registers.
// Depends on blist_pkg; drives the control struct of the cell chain.
module blist_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [blist_pkg::OP_W-1:0]    opcode,
    input  logic [blist_pkg::POS_W-1:0]   position,
    input  logic [blist_pkg::WORD_W-1:0]  word_in,
    input  logic [blist_pkg::WORD_W-1:0]  head_word,
    output blist_pkg::blist_chain_t       chain,
    output logic                          busy,
    output logic                          result_valid,
    output logic                          status,
    output logic [blist_pkg::CNT_W-1:0]   element_count,
    output logic [blist_pkg::WORD_W-1:0]  word_out,
    output logic                          has_word,
    output logic                          last
);
    import blist_pkg::*;

    localparam logic [IDX_W-1:0] MAX_FILL = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic              valid_reg, valid_next;
    logic              status_reg, status_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              has_reg, has_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              ok;
    logic              full;
    logic [IDX_W-1:0]  pos_x;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg == MAX_FILL);
    assign pos_x  = IDX_W'(position);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        valid_next  = 1'b0;
        status_next = 1'b0;
        word_next   = '0;
        has_next    = 1'b0;
        last_next   = 1'b1;
        ok          = 1'b0;

        chain.cmd  = CMD_HOLD;
        chain.pos  = pos_x;
        chain.fill = count_reg;
        chain.word = word_in;

        if (state_reg == ST_DUMP)
        begin
            chain.cmd  = CMD_ROTATE;
            valid_next = 1'b1;
            word_next  = head_word;
            has_next   = 1'b1;
            last_next  = (rem_reg == ONE);
            rem_next   = rem_reg - ONE;
            if (rem_reg == ONE)
                state_next = ST_IDLE;
        end
        else if (accept)
        begin
            valid_next = 1'b1;
            case (opcode)
                OP_APPEND:
                begin
                    ok        = !full;
                    chain.cmd = CMD_INSERT;
                    chain.pos = count_reg;
                end
                OP_REM_FIRST:
                begin
                    ok        = (count_reg != '0);
                    chain.cmd = CMD_REMOVE;
                    chain.pos = '0;
                end
                OP_REM_LAST:
                begin
                    ok        = (count_reg != '0);
                    chain.cmd = CMD_REMOVE;
                    chain.pos = count_reg - ONE;
                end
                OP_INSERT:
                begin
                    ok        = !full && (pos_x <= count_reg);
                    chain.cmd = CMD_INSERT;
                end
                OP_REM_AT:
                begin
                    ok        = (pos_x < count_reg);
                    chain.cmd = CMD_REMOVE;
                end
                OP_DUMP:
                begin
                    ok = 1'b1;
                    // non-empty dump streams from the chain instead
                    if (count_reg != '0)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_DUMP;
                        rem_next   = count_reg;
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase

            if (!ok)
                chain.cmd = CMD_HOLD;
            if (chain.cmd == CMD_INSERT)
                count_next = count_reg + ONE;
            else if (chain.cmd == CMD_REMOVE)
                count_next = count_reg - ONE;
            status_next = !ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rem_reg    <= '0;
            valid_reg  <= 1'b0;
            status_reg <= 1'b0;
            word_reg   <= '0;
            has_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
            word_reg   <= word_next;
            has_reg    <= has_next;
            last_reg   <= last_next;
        end
    end

    assign busy          = (state_reg == ST_DUMP);
    assign result_valid  = valid_reg;
    assign status        = status_reg;
    assign element_count = count_reg[CNT_W-1:0];
    assign word_out      = word_reg;
    assign has_word      = has_reg;
    assign last          = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_FILL)
        else $error("element count above depth");

    a_dump_emits: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> valid_reg && has_reg)
        else $error("dump cycle without element result");

    a_count_hold_dump: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(count_reg))
        else $error("count changed during dump");

    a_mid_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> busy)
        else $error("non-final result outside dump");

    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !has_reg |-> last_reg && (word_reg == '0))
        else $error("plain result not final or word not zero");

endmodule

FILE: rtl/bounded_indexed_list_top.sv
// Top level of the bounded indexed list: sequencer plus a chain of DEPTH cells.
// Depends on blist_pkg, blist_cell and blist_ctrl.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. opcode selects append, remove first, remove last, insert
//   at position, remove at position or dump; word_in is the value stored.
//   Result channel: result_valid is high for exactly one cycle per result;
//   status, element_count, word_out, has_word and last are valid with it.
//   The receiver cannot stall; every result must be taken as it appears.
// Sequencing:
//   Insert, append and every remove shift the whole cell chain at once when
//   accepted; the result is registered and appears in the cycle after the
//   command and busy stays low, so a command may be issued every cycle.
//   Dump of N elements rotates the chain once per cycle and reads the head
//   cell: busy is high while the dump runs, and the N results follow one per
//   cycle, since each head word read in a dump cycle is registered before it
//   reaches the outputs. The N-th rotation restores the order; the next command
//   is taken once busy drops, while the final element is on the outputs.
//   An empty dump gives one result in the cycle after the command, like the rest.
// Reset:
//   rst_n clears the count, so the list is empty; cell contents are not
//   cleared and are only read below the count.
module bounded_indexed_list_top #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [blist_pkg::OP_W-1:0]    opcode,
    input  logic [blist_pkg::POS_W-1:0]   position,
    input  logic [blist_pkg::WORD_W-1:0]  word_in,
    output logic                          result_valid,
    output logic                          status,
    output logic [blist_pkg::CNT_W-1:0]   element_count,
    output logic [blist_pkg::WORD_W-1:0]  word_out,
    output logic                          has_word,
    output logic                          last
);
    import blist_pkg::*;

    blist_chain_t      chain;
    // words[i] is the content of cell i; element 0 sits at the front
    logic [WORD_W-1:0] words [DEPTH];

    blist_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .position      (position),
        .word_in       (word_in),
        .head_word     (words[0]),
        .chain         (chain),
        .busy          (busy),
        .result_valid  (result_valid),
        .status        (status),
        .element_count (element_count),
        .word_out      (word_out),
        .has_word      (has_word),
        .last          (last)
    );

    // Each cell sees both neighbors; insert pulls from the left, remove and
    // rotate pull from the right. The ends get the command word, which a legal
    // command never selects, and zero, which only a remove takes into the last cell.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_front
            assign left_w = word_in;
        end
        else
        begin : g_inner_l
            assign left_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = words[i+1];
        end

        blist_cell #(
            .IDX(i)
        ) u_cell (
            .clk        (clk),
            .chain      (chain),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (words[0]),
            .word       (words[i])
        );
    end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for bounded_indexed_list_top: drives list commands,
// predicts each result in a scoreboard class and checks the result strobes.
// Depends on blist_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;

    import blist_pkg::*;

    localparam int LIST_DEPTH    = 32;
    localparam int CLK_HALF      = 4;         // 8 ns period
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_GAP       = 14;        // longest idle stretch between commands
    localparam int RANDOM_ITEMS  = 310;       // plus ~22 directed ones
    localparam int DRAIN_CYCLES  = LIST_DEPTH + 8;
    localparam int TIMEOUT_NS    = 2_000_000; // far above the slowest legal run

    // Opcodes the block does not define; both must be rejected.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Random phase shapes: grow pushes the list toward full, shrink toward
    // empty, mixed wanders around the middle.
    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} phase_mode_t;

    // One result strobe as the block should present it.
    typedef struct {
        logic              status;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] word;
        logic              has_word;
        logic              last;
    } list_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the list, predicts the results of
    // every accepted transaction and matches them against the strobes.
    // ------------------------------------------------------------------
    class list_scoreboard;
        logic [WORD_W-1:0] words[$];      // predicted list, index 0 = front
        list_result_t      pending_q[$];  // results still owed by the block
        int unsigned       cmds, results, dumped, rejects, peak, mismatches;

        function int stored();
            return words.size();
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function bit put_at(int unsigned idx, logic [WORD_W-1:0] w);
            if (words.size() >= LIST_DEPTH || idx > words.size())
                return 0;
            words.insert(idx, w);
            return 1;
        endfunction

        function bit take_at(int unsigned idx);
            if (idx >= words.size())
                return 0;
            words.delete(idx);
            return 1;
        endfunction

        function void push_result(logic st, logic [WORD_W-1:0] w, logic has, logic fin);
            list_result_t r;
            r.status   = st;
            r.count    = CNT_W'(words.size());
            r.word     = w;
            r.has_word = has;
            r.last     = fin;
            pending_q.push_back(r);
        endfunction

        // Called once per accepted transaction, in acceptance order.
        function void note_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] w);
            bit ok;
            int n;
            cmds++;
            ok = 0;
            case (op)
                OP_APPEND:    ok = put_at(words.size(), w);
                OP_REM_FIRST: ok = take_at(0);
                OP_REM_LAST:  ok = (words.size() != 0) && take_at(words.size() - 1);
                OP_INSERT:    ok = put_at(pos, w);
                OP_REM_AT:    ok = take_at(pos);
                OP_DUMP:
                begin
                    n = words.size();
                    if (n == 0)
                        push_result(STATUS_DONE, '0, 1'b0, 1'b1);
                    for (int i = 0; i < n; i++)
                        push_result(STATUS_DONE, words[i], 1'b1, i == n - 1);
                    return;
                end
                default:      ok = 0;
            endcase
            if (!ok)
                rejects++;
            if (words.size() > peak)
                peak = words.size();
            push_result(ok ? STATUS_DONE : STATUS_REJECT, '0, 1'b0, 1'b1);
        endfunction

        function void match_field(string name, logic [WORD_W-1:0] exp_v,
                                  logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                mismatches++;
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            end
        endfunction

        // Called for every result strobe seen at a rising edge.
        function void check_result(logic st, logic [CNT_W-1:0] cnt, logic [WORD_W-1:0] w,
                                   logic has, logic fin);
            list_result_t e;
            results++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                $error("result with nothing expected: status %0d count %0d word 0x%0h",
                       st, cnt, w);
                return;
            end
            e = pending_q.pop_front();
            if (e.has_word)
                dumped++;
            match_field("status", e.status, st);
            match_field("element_count", e.count, cnt);
            match_field("word_out", e.word, w);
            match_field("has_word", e.has_word, has);
            match_field("last", e.last, fin);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic [OP_W-1:0]   opcode   = OP_APPEND;
    logic [POS_W-1:0]  position = '0;
    logic [WORD_W-1:0] word_in  = '0;
    logic              busy;
    logic              result_valid;
    logic              status;
    logic [CNT_W-1:0]  element_count;
    logic [WORD_W-1:0] word_out;
    logic              has_word;
    logic              last;

    bounded_indexed_list_top #(.DEPTH(LIST_DEPTH)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .position      (position),
        .word_in       (word_in),
        .result_valid  (result_valid),
        .status        (status),
        .element_count (element_count),
        .word_out      (word_out),
        .has_word      (has_word),
        .last          (last)
    );

    list_scoreboard sb = new();

    // When set, commands go back to back with start held high.
    bit no_idle = 0;

    always #CLK_HALF clk = ~clk;

    // Result monitor: the block cannot be stalled, so every strobe is taken
    // at the rising edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(status, element_count, word_out, has_word, last);
    end

    // Issue one command transaction. Called and returns at a falling edge.
    // An optional idle gap comes first; then the fields are held until a
    // rising edge sees busy low, which is where the transaction is taken.
    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [WORD_W-1:0] w);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        position <= pos;
        word_in  <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(op, pos, w);
        @(negedge clk);
    endtask

    // Hard stop in case the block hangs or drops results.
    initial
    begin
        #TIMEOUT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        phase_mode_t       mode;
        int                sent, span, k, cnt;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] w;
        bit                grow_op;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- Directed: empty-list rejects, index edges, dumps, bad opcodes ----
        issue(OP_DUMP,      '0, '0);              // empty dump: single blank result
        issue(OP_REM_FIRST, '0, '0);              // remove from empty list
        issue(OP_REM_LAST,  '0, '0);
        issue(OP_REM_AT,    '0, '0);
        issue(OP_INSERT,    6'd1, 32'h1234_5678); // index above count
        no_idle = 1;
        issue(OP_INSERT,    6'd0, 32'hFFFF_FFFF);
        issue(OP_APPEND,    6'h3F, 32'h0000_0000); // position ignored by append
        issue(OP_INSERT,    6'd2, 32'hA5A5_A5A5); // index == count acts as append
        issue(OP_INSERT,    6'd1, 32'h5A5A_5A5A);
        issue(OP_REM_AT,    6'd4, '0);            // index == count: rejected
        issue(OP_REM_AT,    6'h3F, '0);
        issue(OP_INSERT,    6'h3F, 32'hDEAD_BEEF);
        issue(OP_DUMP,      '0, '0);
        no_idle = 0;
        issue(OP_UNUSED_6,  6'h3F, 32'hFFFF_FFFF);
        issue(OP_UNUSED_7,  6'h2A, 32'h0F0F_0F0F);
        issue(OP_REM_AT,    6'd1, '0);
        issue(OP_REM_LAST,  '0, '0);
        issue(OP_REM_FIRST, '0, '0);
        issue(OP_DUMP,      '0, '0);
        issue(OP_REM_FIRST, '0, '0);              // back to empty
        issue(OP_APPEND,    '0, 32'h8000_0001);
        issue(OP_DUMP,      '0, '0);              // single-element dump

        // ---- Random: phases that steer the fill level up and down ----
        // The first phase grows so the full-list rejects show up early.
        sent = 0;
        mode = MODE_GROW;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 2) == 0);
            span = $urandom_range(40, 70);
            // last phase is cut short so the total stays on target
            if (span > RANDOM_ITEMS - sent)
                span = RANDOM_ITEMS - sent;
            repeat (span)
            begin
                cnt = sb.stored();
                k = $urandom_range(0, 99);
                case (mode)
                    MODE_GROW:   grow_op = ($urandom_range(0, 99) < 85);
                    MODE_SHRINK: grow_op = ($urandom_range(0, 99) < 15);
                    default:     grow_op = ($urandom_range(0, 99) < 50);
                endcase
                if (k < 2)
                    op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7;
                else if (k < 12)
                    op = OP_DUMP;
                else if (grow_op)
                    op = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_REM_FIRST;
                        1:       op = OP_REM_LAST;
                        default: op = OP_REM_AT;
                    endcase
                end
                // Mostly legal indexes for the current fill, sometimes anything.
                if ($urandom_range(0, 9) < 8)
                begin
                    if (op == OP_REM_AT)
                        pos = (cnt > 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
                    else
                        pos = POS_W'($urandom_range(0, cnt));
                end
                else
                    pos = POS_W'($urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = $urandom;
                endcase
                issue(op, pos, w);
                sent++;
            end
            mode = phase_mode_t'($urandom_range(0, 2));
        end

        start <= 1'b0;

        // Wait for every owed result, then a little longer to catch extras.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d list commands (%0d rejected), checked %0d results incl. %0d dumped words",
                 sb.cmds, sb.rejects, sb.results, sb.dumped);
        $display("Peak fill %0d of %0d; %0d mismatches", sb.peak, LIST_DEPTH, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
